// ===== sv/fsh_pkg.sv =====
// Shared types, constants and helper functions for the folded string hash block.
`default_nettype none

package fsh_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NBYTES_W    = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned DIV_STEPS   = WORD_W;
    localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] BUCKET_COUNT_RESET = 32'd11;

    // Valid-byte codes
    localparam logic [NBYTES_W-1:0] NB_NONE  = 3'd0;
    localparam logic [NBYTES_W-1:0] NB_ONE   = 3'd1;
    localparam logic [NBYTES_W-1:0] NB_TWO   = 3'd2;
    localparam logic [NBYTES_W-1:0] NB_THREE = 3'd3;

    // One finished fold on its way to the divider
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] fold;
    } fold_item_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_WAIT
    } div_state_t;

    // Keep the leading valid bytes, zero the rest; 4 and above keep all
    function automatic logic [WORD_W-1:0] keep_mask(input logic [NBYTES_W-1:0] nbytes);
        logic [WORD_W-1:0] m;
        unique case (nbytes)
            NB_NONE:  m = 32'h0000_0000;
            NB_ONE:   m = 32'hFF00_0000;
            NB_TWO:   m = 32'hFFFF_0000;
            NB_THREE: m = 32'hFFFF_FF00;
            default:  m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Mirror a word end for end (pure wiring)
    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = x[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fsh_front.sv =====
// Front end: masks chunks, mirrors even ones and XOR-folds into the accumulator.
`default_nettype none

module fsh_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [fsh_pkg::WORD_W-1:0]     chunk_word,
    input  wire logic [fsh_pkg::NBYTES_W-1:0]   valid_bytes,
    input  wire logic                           last_chunk,
    output fsh_pkg::fold_item_t                 wr_item
);

    logic [fsh_pkg::WORD_W-1:0] acc_reg;
    logic [fsh_pkg::WORD_W-1:0] acc_next;
    logic                       odd_reg;
    logic                       odd_next;
    logic [fsh_pkg::WORD_W-1:0] masked;
    logic [fsh_pkg::WORD_W-1:0] shaped;
    logic [fsh_pkg::WORD_W-1:0] fold_value;

    // Chunk shaping: byte mask, then mirror at even positions
    always_comb
    begin
        masked     = chunk_word & fsh_pkg::keep_mask(valid_bytes);
        shaped     = odd_reg ? masked : fsh_pkg::bit_reverse(masked);
        fold_value = acc_reg ^ shaped;
    end

    // Accumulator update; a last chunk hands the fold on and clears the state
    always_comb
    begin
        acc_next = acc_reg;
        odd_next = odd_reg;
        if (accept)
        begin
            if (last_chunk)
            begin
                acc_next = '0;
                odd_next = 1'b0;
            end
            else
            begin
                acc_next = fold_value;
                odd_next = ~odd_reg;
            end
        end
        wr_item.valid = accept && last_chunk;
        wr_item.fold  = fold_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            odd_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            odd_reg <= odd_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_chunk) |=> (acc_reg == '0 && !odd_reg))
        else $error("fold state not cleared after last chunk");
`endif

endmodule

`default_nettype wire

// ===== sv/fsh_queue.sv =====
// Short queue of finished folds between the front end and the divider.
`default_nettype none

module fsh_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fsh_pkg::fold_item_t wr_item,
    output logic                     full,
    output fsh_pkg::fold_item_t      head,
    input  wire logic                head_pop
);

    logic [fsh_pkg::WORD_W-1:0] mem_reg [fsh_pkg::QUEUE_DEPTH];
    logic [fsh_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fsh_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [fsh_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fsh_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [fsh_pkg::QCNT_W-1:0] count_reg;
    logic [fsh_pkg::QCNT_W-1:0] count_next;
    logic                       do_wr;
    logic                       do_rd;

    localparam logic [fsh_pkg::QPTR_W-1:0] PTR_LAST = fsh_pkg::QPTR_W'(fsh_pkg::QUEUE_DEPTH - 1);
    localparam logic [fsh_pkg::QCNT_W-1:0] CNT_FULL = fsh_pkg::QCNT_W'(fsh_pkg::QUEUE_DEPTH);

    // Status and head item
    always_comb
    begin
        full       = (count_reg == CNT_FULL);
        head.valid = (count_reg != '0);
        head.fold  = mem_reg[rd_ptr_reg];
        do_wr      = wr_item.valid && !full;
        do_rd      = head_pop && head.valid;
    end

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item.fold;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_item.valid |-> (count_reg < CNT_FULL))
        else $error("fold written into a full queue");
`endif

endmodule

`default_nettype wire

// ===== sv/fsh_divider.sv =====
// Back end: bit-serial restoring remainder of each fold, plus the result register.
`default_nettype none

module fsh_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fsh_pkg::fold_item_t        head,
    output logic                            head_pop,
    input  wire logic [fsh_pkg::WORD_W-1:0] divisor,
    output logic                            out_valid,
    output logic [fsh_pkg::WORD_W-1:0]      out_data,
    input  wire logic                       out_pop
);

    fsh_pkg::div_state_t         state_reg;
    fsh_pkg::div_state_t         state_next;
    logic [fsh_pkg::STEP_W-1:0]  step_reg;
    logic [fsh_pkg::STEP_W-1:0]  step_next;
    logic [fsh_pkg::WORD_W-1:0]  rem_reg;
    logic [fsh_pkg::WORD_W-1:0]  rem_next;
    logic [fsh_pkg::WORD_W-1:0]  dvd_reg;
    logic [fsh_pkg::WORD_W-1:0]  dvd_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [fsh_pkg::WORD_W-1:0]  out_reg;
    logic [fsh_pkg::WORD_W-1:0]  out_next;
    logic [fsh_pkg::WORD_W:0]    trial;
    logic [fsh_pkg::WORD_W:0]    diff;
    logic [fsh_pkg::WORD_W-1:0]  rem_step;
    logic                        slot_free;

    localparam logic [fsh_pkg::STEP_W-1:0] STEP_LAST = fsh_pkg::STEP_W'(fsh_pkg::DIV_STEPS - 1);

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[fsh_pkg::WORD_W-1]};
        diff     = trial - {1'b0, divisor};
        rem_step = diff[fsh_pkg::WORD_W] ? trial[fsh_pkg::WORD_W-1:0]
                                         : diff[fsh_pkg::WORD_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        head_pop       = 1'b0;
        slot_free      = !out_valid_reg || out_pop;

        if (out_valid_reg && out_pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fsh_pkg::DIV_IDLE:
            begin
                if (head.valid)
                begin
                    head_pop  = 1'b1;
                    step_next = '0;
                    if (divisor == '0)
                    begin
                        // zero divisor passes the fold through
                        rem_next   = head.fold;
                        state_next = fsh_pkg::DIV_WAIT;
                    end
                    else
                    begin
                        rem_next   = '0;
                        dvd_next   = head.fold;
                        state_next = fsh_pkg::DIV_RUN;
                    end
                end
            end
            fsh_pkg::DIV_RUN:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[fsh_pkg::WORD_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = fsh_pkg::DIV_WAIT;
                end
            end
            fsh_pkg::DIV_WAIT:
            begin
                // hand the remainder to the result register once it is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = rem_reg;
                    state_next     = fsh_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = fsh_pkg::DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsh_pkg::DIV_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_run_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fsh_pkg::DIV_IDLE && head.valid && divisor != '0)
        |=> (state_reg == fsh_pkg::DIV_RUN && step_reg == '0))
        else $error("division did not start from step zero");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (state_reg == fsh_pkg::DIV_IDLE && head.valid))
        else $error("queue popped outside idle or while empty");
`endif

endmodule

`default_nettype wire

// ===== sv/folded_string_hash_top.sv =====
// Top level of the folded string hash: config register, front end, queue, divider.
//
//  channel   handshake             payload
//  --------  --------------------  ------------------------------------------
//  input     push / full           chunk_word[31:0], valid_bytes[2:0], last_chunk
//  result    empty / pop           bucket_index[31:0]
//  config    cfg_valid / cfg_ready bucket_count[31:0]
//
// The front end folds one chunk per cycle while full is low; full rises only while
// the two-entry fold queue is full. For each key the divider loads the fold, runs
// a 32-step restoring remainder and hands it off (a zero bucket count skips it).
// Reset (rst_n low, asynchronous) clears the fold, the queue and the result,
// and sets the bucket count to 11. cfg_ready is always high. A waiting result
// does not stop the divider from working on the next key.
`default_nettype none

module folded_string_hash_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [fsh_pkg::WORD_W-1:0]     chunk_word,
    input  wire logic [fsh_pkg::NBYTES_W-1:0]   valid_bytes,
    input  wire logic                           last_chunk,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [fsh_pkg::WORD_W-1:0]          bucket_index,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fsh_pkg::WORD_W-1:0]     bucket_count
);

    logic [fsh_pkg::WORD_W-1:0] bucket_count_reg;
    logic [fsh_pkg::WORD_W-1:0] bucket_count_next;
    logic                       accept;
    logic                       q_full;
    logic                       head_pop;
    logic                       out_valid;
    fsh_pkg::fold_item_t        wr_item;
    fsh_pkg::fold_item_t        head;

    // Configuration register
    always_comb
    begin
        cfg_ready         = 1'b1;
        bucket_count_next = (cfg_valid && cfg_ready) ? bucket_count : bucket_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= fsh_pkg::BUCKET_COUNT_RESET;
        end
        else
        begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    fsh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .chunk_word  (chunk_word),
        .valid_bytes (valid_bytes),
        .last_chunk  (last_chunk),
        .wr_item     (wr_item)
    );

    fsh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (wr_item),
        .full     (q_full),
        .head     (head),
        .head_pop (head_pop)
    );

    fsh_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_pop  (head_pop),
        .divisor   (bucket_count_reg),
        .out_valid (out_valid),
        .out_data  (bucket_index),
        .out_pop   (pop)
    );

endmodule

`default_nettype wire

// ===== dv/tb_folded_string_hash_top.sv =====
// Self-checking testbench for the folded string hash top level.
module tb_folded_string_hash_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fsh_pkg::NBYTES_W-1:0] NB_FULL = 3'd4;
    localparam int DIV_SETTLE   = 40;   // lets the divider finish its last key
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 70;

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic [fsh_pkg::WORD_W-1:0]   chunk_word;
    logic [fsh_pkg::NBYTES_W-1:0] valid_bytes;
    logic                         last_chunk;
    logic                         empty;
    logic                         pop;
    logic [fsh_pkg::WORD_W-1:0]   bucket_index;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [fsh_pkg::WORD_W-1:0]   bucket_count;

    // Predictor state
    logic [fsh_pkg::WORD_W-1:0]   fold_acc;
    bit                           odd_chunk;
    logic [fsh_pkg::WORD_W-1:0]   model_bucket_count;
    logic [fsh_pkg::WORD_W-1:0]   exp_buckets[$];

    int  error_count = 0;
    int  items_sent  = 0;
    bit  src_idle_en = 1'b1;
    bit  rcv_idle_en = 1'b1;
    int  hold_req    = 0;

    folded_string_hash_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .chunk_word   (chunk_word),
        .valid_bytes  (valid_bytes),
        .last_chunk   (last_chunk),
        .empty        (empty),
        .pop          (pop),
        .bucket_index (bucket_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .bucket_count (bucket_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Fold one chunk into the predictor; returns 1 when a bucket comes out
    function automatic bit fold_chunk(input logic [fsh_pkg::WORD_W-1:0] word,
                                      input logic [fsh_pkg::NBYTES_W-1:0] nb,
                                      input logic last,
                                      output logic [fsh_pkg::WORD_W-1:0] bucket);
        logic [fsh_pkg::WORD_W-1:0] kept;
        logic [fsh_pkg::WORD_W-1:0] mirrored;
        kept = (nb >= NB_FULL) ? word : word & ~(32'hFFFF_FFFF >> (8 * nb));
        for (int i = 0; i < fsh_pkg::WORD_W; i++)
        begin
            mirrored[i] = kept[fsh_pkg::WORD_W-1-i];
        end
        fold_acc  = fold_acc ^ (odd_chunk ? kept : mirrored);
        odd_chunk = ~odd_chunk;
        bucket    = '0;
        if (!last)
        begin
            return 1'b0;
        end
        bucket    = (model_bucket_count == '0) ? fold_acc
                                               : fold_acc % model_bucket_count;
        fold_acc  = '0;
        odd_chunk = 1'b0;
        return 1'b1;
    endfunction

    // Offer one chunk until taken, predict, then maybe idle a burst
    task automatic send_chunk(input logic [fsh_pkg::WORD_W-1:0] word,
                              input logic [fsh_pkg::NBYTES_W-1:0] nb,
                              input logic last);
        logic [fsh_pkg::WORD_W-1:0] bucket;
        push        <= 1'b1;
        chunk_word  <= word;
        valid_bytes <= nb;
        last_chunk  <= last;
        do @(posedge clk); while (full);
        if (fold_chunk(word, nb, last, bucket))
        begin
            exp_buckets = {exp_buckets, bucket};
        end
        items_sent++;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Random key; a fifth of keys carry any byte count on any chunk
    task automatic send_random_key(input int max_len);
        int len;
        bit noisy;
        logic [fsh_pkg::NBYTES_W-1:0] nb;
        len   = $urandom_range(1, max_len);
        noisy = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                nb = fsh_pkg::NBYTES_W'($urandom_range(0, 7));
            else if (i == len - 1)
                nb = fsh_pkg::NBYTES_W'($urandom_range(1, 4));
            else
                nb = NB_FULL;
            send_chunk($urandom, nb, i == len - 1);
        end
    endtask

    // Stop sending and wait for every expected bucket, then let the divider settle
    task automatic wait_all_results();
        push <= 1'b0;
        while (exp_buckets.size() != 0) @(posedge clk);
        repeat (DIV_SETTLE) @(posedge clk);
    endtask

    // Bucket count write, only called while idle
    task automatic write_bucket_count(input logic [fsh_pkg::WORD_W-1:0] size);
        cfg_valid    <= 1'b1;
        bucket_count <= size;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid          <= 1'b0;
        model_bucket_count  = size;
    endtask

    function automatic logic [fsh_pkg::WORD_W-1:0] pick_bucket_count();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(2, 64);
            1:       return $urandom;
            2:       return $urandom_range(2, 100_000);
            3:       return '0;
            4:       return 32'd1;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Reset-time bucket count with extreme words
    task automatic test_default_size();
        send_chunk(32'hFFFF_FFFF, NB_FULL, 1'b1);
        send_chunk(32'h0000_0000, NB_FULL, 1'b1);
        send_chunk(32'h8000_0001, NB_FULL, 1'b1);
    endtask

    // Every byte count on a last chunk, and short chunks mid-key
    task automatic test_byte_counts();
        for (int nb = 0; nb < 8; nb++)
        begin
            send_chunk(32'hA5C3_96E1, fsh_pkg::NBYTES_W'(nb), 1'b1);
        end
        send_chunk(32'h1234_5678, fsh_pkg::NB_ONE, 1'b0);
        send_chunk(32'h9ABC_DEF0, fsh_pkg::NB_THREE, 1'b0);
        send_chunk(32'hFFFF_FFFF, NB_FULL, 1'b1);
    endtask

    // Zero, unit, largest and smallest normal divisors
    task automatic test_divisor_extremes();
        logic [fsh_pkg::WORD_W-1:0] sizes[4];
        sizes = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2};
        foreach (sizes[i])
        begin
            wait_all_results();
            write_bucket_count(sizes[i]);
            send_chunk(32'hFFFF_FFFF, NB_FULL, 1'b0);
            send_chunk(32'h0F0F_F0F0, fsh_pkg::NB_TWO, 1'b1);
        end
    endtask

    // Random keys over several bucket counts
    task automatic test_random_keys();
        int goal;
        for (int p = 0; p < 6; p++)
        begin
            wait_all_results();
            write_bucket_count(pick_bucket_count());
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                send_random_key(6);
            end
        end
    endtask

    // Long receiver stall while chunks keep coming, so input stalls
    task automatic test_backpressure();
        int goal;
        wait_all_results();
        write_bucket_count(pick_bucket_count());
        src_idle_en = 1'b0;
        hold_req    = HOLD_CYCLES;
        goal        = items_sent + 40;
        while (items_sent < goal)
        begin
            send_random_key(2);
        end
        src_idle_en = 1'b1;
        wait_all_results();
    endtask

    // Full rate on both sides
    task automatic test_full_rate();
        int goal;
        src_idle_en = 1'b0;
        rcv_idle_en = 1'b0;
        write_bucket_count($urandom_range(2, 1000));
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            send_random_key(4);
        end
    endtask

    // Result side: random pops, idle bursts, and the long hold on request
    initial
    begin
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req > 0)
            begin
                pop <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            else if (rcv_idle_en && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each popped bucket against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (exp_buckets.size() == 0)
            begin
                $display("%0t: unexpected bucket_index, expected none, actual %h",
                         $time, bucket_index);
                error_count++;
            end
            else
            begin
                if (bucket_index !== exp_buckets[0])
                begin
                    $display("%0t: bucket_index mismatch, expected %h, actual %h",
                             $time, exp_buckets[0], bucket_index);
                    error_count++;
                end
                void'(exp_buckets.pop_front());
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n        <= 1'b0;
        push         <= 1'b0;
        chunk_word   <= '0;
        valid_bytes  <= '0;
        last_chunk   <= 1'b0;
        cfg_valid    <= 1'b0;
        bucket_count <= '0;
        fold_acc           = '0;
        odd_chunk          = 1'b0;
        model_bucket_count = fsh_pkg::BUCKET_COUNT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_byte_counts();
        test_divisor_extremes();
        test_random_keys();
        test_backpressure();
        test_full_rate();

        wait_all_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
